@@ src/msie_pkg.sv @@
// Shared types and constants for the MIPS subset instruction executor.
package msie_pkg;

  localparam logic [31:0] START_PC_RST  = 32'h0040_0000;
  localparam logic [31:0] DATA_BASE_RST = 32'h1000_0000;

  localparam logic CFG_DATA_BASE = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_UNSUP = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_ADDIU   = 6'h09;
  localparam logic [5:0] OP_SLTIU   = 6'h0B;
  localparam logic [5:0] OP_ANDI    = 6'h0C;
  localparam logic [5:0] OP_ORI     = 6'h0D;
  localparam logic [5:0] OP_LUI     = 6'h0F;
  localparam logic [5:0] OP_LB      = 6'h20;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_SB      = 6'h28;
  localparam logic [5:0] OP_SW      = 6'h2B;

  localparam logic [5:0] FN_SLL  = 6'h00;
  localparam logic [5:0] FN_SRL  = 6'h02;
  localparam logic [5:0] FN_JR   = 6'h08;
  localparam logic [5:0] FN_ADDU = 6'h21;
  localparam logic [5:0] FN_SUBU = 6'h23;
  localparam logic [5:0] FN_AND  = 6'h24;
  localparam logic [5:0] FN_OR   = 6'h25;
  localparam logic [5:0] FN_NOR  = 6'h27;
  localparam logic [5:0] FN_SLTU = 6'h2B;

  typedef struct packed {
    logic [31:0] npc;
    logic        rwe;
    logic [4:0]  ridx;
    logic [31:0] rval;
    logic        ld_word;
    logic        ld_byte;
    logic        mwe;
    logic        sb;
    logic [9:0]  midx;
    logic [31:0] mval;
    logic [1:0]  lane;
    logic [1:0]  status;
  } ex_t;

endpackage

@@ src/mips_subset_instruction_executor_top.sv @@
// Top level: operand stage, execute/memory stage and result register of the executor.
// A request passes the operand register, the memory-stage register and the result register before its result is shown.
// Throughput: one request per cycle, set by the single RF and dmem ports, when not stalled.
// Load results forward from the memory stage, so dependent requests never wait.
// Reset: control cleared, pc back to 0x00400000, data_base back to 0x10000000,
// registers read zero; data memory is undefined until written and is not swept.
module mips_subset_instruction_executor_top #(
  parameter int DATA_WORDS = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        action_i,
  input  logic [31:0] instr_i,
  input  logic [9:0]  load_index_i,
  input  logic [31:0] load_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] next_pc_o,
  output logic        reg_we_o,
  output logic [4:0]  reg_index_o,
  output logic [31:0] reg_value_o,
  output logic        mem_we_o,
  output logic [9:0]  mem_index_o,
  output logic [31:0] mem_value_o,
  output logic [1:0]  status_o
);

  localparam int AW = $clog2(DATA_WORDS);

  logic          out_free;
  logic          s2_go;
  logic          s2_load;
  logic          s1_go;
  logic          s1_load;
  logic          accept;

  logic          s1_valid_q;
  logic          s1_action_q;
  logic [31:0]   s1_instr_q;
  logic [9:0]    s1_li_q;
  logic [31:0]   s1_lv_q;
  logic          s2_valid_q;
  msie_pkg::ex_t s2_ex_q;
  logic [AW-1:0] s2_addr_q;
  logic [31:0]   pc_q;
  logic [31:0]   data_base_q;

  logic [31:0]   rf_a;
  logic [31:0]   rf_b;
  logic [31:0]   op_a;
  logic [31:0]   op_b;
  msie_pkg::ex_t ex;
  logic [AW-1:0] ex_addr;
  logic [31:0]   dm_rdata;
  logic [7:0]    ld_byte;
  logic [31:0]   sb_word;
  logic [31:0]   rval_fin;
  logic [31:0]   mval_fin;
  logic          fwd_a;
  logic          fwd_b;

  logic          out_valid_q;
  logic [31:0]   out_npc_q;
  logic          out_rwe_q;
  logic [4:0]    out_ridx_q;
  logic [31:0]   out_rval_q;
  logic          out_mwe_q;
  logic [9:0]    out_midx_q;
  logic [31:0]   out_mval_q;
  logic [1:0]    out_status_q;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s2_go      = s2_valid_q && out_free;
  assign s2_load    = !s2_valid_q || out_free;
  assign s1_go      = s1_valid_q && s2_load;
  assign s1_load    = !s1_valid_q || s2_load;
  assign accept     = in_valid_i && s1_load;
  assign in_stall_o = !s1_load;

  msie_rf u_rf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rd_en_i (accept),
    .ra_i    (instr_i[25:21]),
    .rb_i    (instr_i[20:16]),
    .we_i    (s2_go && s2_ex_q.rwe),
    .wa_i    (s2_ex_q.ridx),
    .wd_i    (rval_fin),
    .rda_o   (rf_a),
    .rdb_o   (rf_b)
  );

  // forward the result of the request in the memory stage
  assign fwd_a = s2_valid_q && s2_ex_q.rwe && (s2_ex_q.ridx == s1_instr_q[25:21]);
  assign fwd_b = s2_valid_q && s2_ex_q.rwe && (s2_ex_q.ridx == s1_instr_q[20:16]);
  assign op_a  = fwd_a ? rval_fin : rf_a;
  assign op_b  = fwd_b ? rval_fin : rf_b;

  msie_exec #(
    .DATA_WORDS (DATA_WORDS)
  ) u_exec (
    .pc_i         (pc_q),
    .data_base_i  (data_base_q),
    .action_i     (s1_action_q),
    .instr_i      (s1_instr_q),
    .load_index_i (s1_li_q),
    .load_value_i (s1_lv_q),
    .op_a_i       (op_a),
    .op_b_i       (op_b),
    .ex_o         (ex),
    .addr_o       (ex_addr)
  );

  msie_dmem #(
    .DATA_WORDS (DATA_WORDS)
  ) u_dmem (
    .clk_i   (clk_i),
    .rd_en_i (s1_go),
    .raddr_i (ex_addr),
    .we_i    (s2_go && s2_ex_q.mwe),
    .waddr_i (s2_addr_q),
    .wdata_i (mval_fin),
    .rdata_o (dm_rdata)
  );

  always_comb begin
    case (s2_ex_q.lane)
      2'd0: begin
        ld_byte = dm_rdata[31:24];
        sb_word = {s2_ex_q.mval[7:0], dm_rdata[23:0]};
      end
      2'd1: begin
        ld_byte = dm_rdata[23:16];
        sb_word = {dm_rdata[31:24], s2_ex_q.mval[7:0], dm_rdata[15:0]};
      end
      2'd2: begin
        ld_byte = dm_rdata[15:8];
        sb_word = {dm_rdata[31:16], s2_ex_q.mval[7:0], dm_rdata[7:0]};
      end
      default: begin
        ld_byte = dm_rdata[7:0];
        sb_word = {dm_rdata[31:8], s2_ex_q.mval[7:0]};
      end
    endcase
  end

  assign rval_fin = s2_ex_q.ld_word ? dm_rdata :
                    s2_ex_q.ld_byte ? {{24{ld_byte[7]}}, ld_byte} : s2_ex_q.rval;
  assign mval_fin = s2_ex_q.sb ? sb_word : s2_ex_q.mval;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pc_q        <= msie_pkg::START_PC_RST;
      data_base_q <= msie_pkg::DATA_BASE_RST;
    end else begin
      s1_valid_q  <= accept || (s1_valid_q && !s1_go);
      s2_valid_q  <= s1_go || (s2_valid_q && !s2_go);
      out_valid_q <= s2_go || (out_valid_q && out_stall_i);
      if (s1_go) begin
        pc_q <= ex.npc;
      end
      if (cfg_we_i && cfg_index_i == msie_pkg::CFG_DATA_BASE) begin
        data_base_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_action_q <= action_i;
      s1_instr_q  <= instr_i;
      s1_li_q     <= load_index_i;
      s1_lv_q     <= load_value_i;
    end
    if (s1_go) begin
      s2_ex_q   <= ex;
      s2_addr_q <= ex_addr;
    end
    if (s2_go) begin
      out_npc_q    <= s2_ex_q.npc;
      out_rwe_q    <= s2_ex_q.rwe;
      out_ridx_q   <= s2_ex_q.rwe ? s2_ex_q.ridx : 5'd0;
      out_rval_q   <= s2_ex_q.rwe ? rval_fin : 32'd0;
      out_mwe_q    <= s2_ex_q.mwe;
      out_midx_q   <= s2_ex_q.mwe ? s2_ex_q.midx : 10'd0;
      out_mval_q   <= s2_ex_q.mwe ? mval_fin : 32'd0;
      out_status_q <= s2_ex_q.status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign next_pc_o   = out_npc_q;
  assign reg_we_o    = out_rwe_q;
  assign reg_index_o = out_ridx_q;
  assign reg_value_o = out_rval_q;
  assign mem_we_o    = out_mwe_q;
  assign mem_index_o = out_midx_q;
  assign mem_value_o = out_mval_q;
  assign status_o    = out_status_q;

endmodule

@@ src/msie_rf.sv @@
// General register file: two registered read ports, one write port, reset-to-zero valid bits.
module msie_rf (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        rd_en_i,
  input  logic [4:0]  ra_i,
  input  logic [4:0]  rb_i,
  input  logic        we_i,
  input  logic [4:0]  wa_i,
  input  logic [31:0] wd_i,
  output logic [31:0] rda_o,
  output logic [31:0] rdb_o
);

  logic [31:0] mem_q [32];
  logic [31:0] vld_q;
  logic [31:0] rda_q;
  logic [31:0] rdb_q;
  logic        oka_q;
  logic        okb_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[wa_i] <= wd_i;
    end
    if (rd_en_i) begin
      rda_q <= (we_i && wa_i == ra_i) ? wd_i : mem_q[ra_i];
      rdb_q <= (we_i && wa_i == rb_i) ? wd_i : mem_q[rb_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      oka_q <= 1'b0;
      okb_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[wa_i] <= 1'b1;
      end
      if (rd_en_i) begin
        oka_q <= (we_i && wa_i == ra_i) || vld_q[ra_i];
        okb_q <= (we_i && wa_i == rb_i) || vld_q[rb_i];
      end
    end
  end

  assign rda_o = oka_q ? rda_q : '0;
  assign rdb_o = okb_q ? rdb_q : '0;

endmodule

@@ src/msie_dmem.sv @@
// Data memory: one write port, one registered read port with write bypass.
module msie_dmem #(
  parameter int DATA_WORDS = 1024
) (
  input  logic                          clk_i,
  input  logic                          rd_en_i,
  input  logic [$clog2(DATA_WORDS)-1:0] raddr_i,
  input  logic                          we_i,
  input  logic [$clog2(DATA_WORDS)-1:0] waddr_i,
  input  logic [31:0]                   wdata_i,
  output logic [31:0]                   rdata_o
);

  logic [31:0] mem_q [DATA_WORDS];
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (rd_en_i) begin
      rdata_q <= (we_i && waddr_i == raddr_i) ? wdata_i : mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/msie_exec.sv @@
// Decode and execute: next PC, register result, address and store data of one request.
module msie_exec #(
  parameter int DATA_WORDS = 1024
) (
  input  logic [31:0]                   pc_i,
  input  logic [31:0]                   data_base_i,
  input  logic                          action_i,
  input  logic [31:0]                   instr_i,
  input  logic [9:0]                    load_index_i,
  input  logic [31:0]                   load_value_i,
  input  logic [31:0]                   op_a_i,
  input  logic [31:0]                   op_b_i,
  output msie_pkg::ex_t                 ex_o,
  output logic [$clog2(DATA_WORDS)-1:0] addr_o
);

  localparam int AW = $clog2(DATA_WORDS);
  localparam logic [29:0] WORDS30 = 30'(DATA_WORDS);
  localparam logic [31:0] WORDS32 = 32'(DATA_WORDS);

  logic [5:0]  op;
  logic [5:0]  fn;
  logic [4:0]  sh;
  logic [4:0]  rt;
  logic [4:0]  rd;
  logic [15:0] imm;
  logic [31:0] simm;
  logic [31:0] zimm;
  logic [31:0] pc4;
  logic [31:0] br_tgt;
  logic [31:0] j_tgt;
  logic [31:0] maddr;
  logic [31:0] moff;
  logic        m_ok;
  logic [31:0] li_ext;
  logic        li_ok;
  logic        rwe_raw;
  msie_pkg::ex_t ex;

  assign op     = instr_i[31:26];
  assign rt     = instr_i[20:16];
  assign rd     = instr_i[15:11];
  assign sh     = instr_i[10:6];
  assign fn     = instr_i[5:0];
  assign imm    = instr_i[15:0];
  assign simm   = {{16{imm[15]}}, imm};
  assign zimm   = {16'h0000, imm};
  assign pc4    = pc_i + 32'd4;
  assign br_tgt = pc4 + {simm[29:0], 2'b00};
  assign j_tgt  = {pc4[31:28], instr_i[25:0], 2'b00};
  assign maddr  = op_a_i + simm;
  assign moff   = maddr - data_base_i;
  assign m_ok   = moff[31:2] < WORDS30;
  assign li_ext = 32'(load_index_i);
  assign li_ok  = li_ext < WORDS32;

  always_comb begin
    ex        = '0;
    ex.npc    = pc4;
    ex.status = msie_pkg::ST_OK;
    rwe_raw   = 1'b0;
    addr_o    = moff[AW+1:2];
    if (action_i) begin
      ex.npc = pc_i;
      addr_o = li_ext[AW-1:0];
      if (li_ok) begin
        ex.mwe  = 1'b1;
        ex.midx = load_index_i;
        ex.mval = load_value_i;
      end else begin
        ex.status = msie_pkg::ST_RANGE;
      end
    end else begin
      unique case (op) inside
        msie_pkg::OP_SPECIAL: begin
          rwe_raw = 1'b1;
          ex.ridx = rd;
          unique case (fn)
            msie_pkg::FN_ADDU: ex.rval = op_a_i + op_b_i;
            msie_pkg::FN_AND:  ex.rval = op_a_i & op_b_i;
            msie_pkg::FN_NOR:  ex.rval = ~(op_a_i | op_b_i);
            msie_pkg::FN_OR:   ex.rval = op_a_i | op_b_i;
            msie_pkg::FN_SLTU: ex.rval = {31'd0, op_a_i < op_b_i};
            msie_pkg::FN_SLL:  ex.rval = op_b_i << sh;
            msie_pkg::FN_SRL:  ex.rval = op_b_i >> sh;
            msie_pkg::FN_SUBU: ex.rval = op_a_i - op_b_i;
            msie_pkg::FN_JR: begin
              rwe_raw = 1'b0;
              ex.npc  = op_a_i;
            end
            default: begin
              rwe_raw   = 1'b0;
              ex.status = msie_pkg::ST_UNSUP;
            end
          endcase
        end
        msie_pkg::OP_J: begin
          ex.npc = j_tgt;
        end
        msie_pkg::OP_JAL: begin
          ex.npc  = j_tgt;
          rwe_raw = 1'b1;
          ex.ridx = 5'd31;
          ex.rval = pc4;
        end
        msie_pkg::OP_BEQ: begin
          if (op_a_i == op_b_i) begin
            ex.npc = br_tgt;
          end
        end
        msie_pkg::OP_BNE: begin
          if (op_a_i != op_b_i) begin
            ex.npc = br_tgt;
          end
        end
        msie_pkg::OP_LW, msie_pkg::OP_LB, msie_pkg::OP_SW, msie_pkg::OP_SB: begin
          ex.lane = moff[1:0];
          if (!m_ok) begin
            ex.status = msie_pkg::ST_RANGE;
          end else if (op == msie_pkg::OP_LW || op == msie_pkg::OP_LB) begin
            rwe_raw    = 1'b1;
            ex.ridx    = rt;
            ex.ld_word = (op == msie_pkg::OP_LW);
            ex.ld_byte = (op == msie_pkg::OP_LB);
          end else begin
            ex.mwe  = 1'b1;
            ex.midx = moff[11:2];
            ex.sb   = (op == msie_pkg::OP_SB);
            ex.mval = (op == msie_pkg::OP_SB) ? {24'd0, op_b_i[7:0]} : op_b_i;
          end
        end
        msie_pkg::OP_ADDIU: begin
          rwe_raw = 1'b1;
          ex.ridx = rt;
          ex.rval = op_a_i + simm;
        end
        msie_pkg::OP_ANDI: begin
          rwe_raw = 1'b1;
          ex.ridx = rt;
          ex.rval = op_a_i & zimm;
        end
        msie_pkg::OP_ORI: begin
          rwe_raw = 1'b1;
          ex.ridx = rt;
          ex.rval = op_a_i | zimm;
        end
        msie_pkg::OP_LUI: begin
          rwe_raw = 1'b1;
          ex.ridx = rt;
          ex.rval = {imm, 16'h0000};
        end
        msie_pkg::OP_SLTIU: begin
          rwe_raw = 1'b1;
          ex.ridx = rt;
          ex.rval = {31'd0, op_a_i < simm};
        end
        default: begin
          ex.status = msie_pkg::ST_UNSUP;
        end
      endcase
    end
    ex.rwe = rwe_raw && (ex.ridx != 5'd0);
  end

  assign ex_o = ex;

endmodule

@@ src/msie_checker.sv @@
// Port-level checks on the executor's result channel, bound to the top level.
module msie_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] next_pc_o,
  input logic        reg_we_o,
  input logic [4:0]  reg_index_o,
  input logic [31:0] reg_value_o,
  input logic        mem_we_o,
  input logic [9:0]  mem_index_o,
  input logic [31:0] mem_value_o,
  input logic [1:0]  status_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(next_pc_o) && $stable(status_o))
    else $error("result changed while stalled");

  a_idle_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (reg_we_o || (reg_index_o == 5'd0 && reg_value_o == 32'd0)) &&
                    (mem_we_o || (mem_index_o == 10'd0 && mem_value_o == 32'd0)))
    else $error("unwritten result fields not zero");

  a_no_reg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && reg_we_o |-> reg_index_o != 5'd0)
    else $error("register zero reported as written");

  a_fault_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != msie_pkg::ST_OK |-> !reg_we_o && !mem_we_o &&
      (status_o == msie_pkg::ST_UNSUP || status_o == msie_pkg::ST_RANGE))
    else $error("faulting request wrote state or bad status");

  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(reg_we_o && mem_we_o))
    else $error("register and memory written by one request");

endmodule

bind mips_subset_instruction_executor_top msie_checker u_msie_checker (.*);
